FILE: design/rlbwe_pkg.sv
// shared types and constants for the rgb led breathing waveform encoder
// no dependencies

package rlbwe_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_COLOR     = 3'd1;
  localparam logic [2:0] REG_LUX       = 3'd2;
  localparam logic [2:0] REG_PERIOD    = 3'd3;
  localparam logic [2:0] REG_DUTY_ONE  = 3'd4;
  localparam logic [2:0] REG_DUTY_ZERO = 3'd5;

  // brightness modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_STEADY  = 2'd1;
  localparam logic [1:0] MODE_BREATHE = 2'd2;

  localparam int DEF_PIXELS      = 1;
  localparam int DEF_RESET_SLOTS = 20;
  localparam int LEAD_SLOTS      = 2;
  localparam int BITS_PER_PIXEL  = 24;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [6:0]  LUX_MAX     = 7'd100;
  localparam logic [13:0] LUX_DIVISOR = 14'd100;
  localparam logic [21:0] FULL_SCALE  = 22'd255;
  localparam logic [13:0] RAMP_STEP   = 14'd50;

  localparam logic [5:0] RST_DUTY_ONE  = 6'd40;
  localparam logic [5:0] RST_DUTY_ZERO = 6'd19;
  localparam logic [7:0] RST_PERIOD    = 8'd1;

  localparam int DVD_W = 22;
  localparam int DIV_W = 14;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] color;
    logic [6:0] lux_percent;
    logic [7:0] breathe_period;
    logic [5:0] duty_one;
    logic [5:0] duty_zero;
  } cfg_t;

  typedef struct packed {
    logic [7:0] bright;
    logic [2:0] color;
  } frame_t;

  // handshake between a queue and its two sides
  typedef struct packed {
    logic push;
    logic pop;
  } q_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: design/rlbwe_front.sv
// front part: accepts ticks, runs the breathing ramp and works out the brightness
// uses rlbwe_pkg; divides with a one bit per cycle restoring divider

module rlbwe_front (
  input  logic              clk,
  input  logic              rst,
  input  rlbwe_pkg::cfg_t   cfg,
  input  logic              tick_valid,
  input  logic              tick,
  output logic              tick_ready,
  output logic              push,
  output rlbwe_pkg::frame_t push_data,
  input  logic              q_full
);
  import rlbwe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);
  // 255 / 100 as a fixed point reciprocal, 19 fraction bits, set above the exact value
  localparam logic [20:0] LUX_RECIP = 21'd1336965;
  localparam int          LUX_SHIFT = 19;

  logic [1:0]        state;
  logic [13:0]       ramp_count;
  logic              ramp_falling;
  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  quot;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [2:0]        color;

  logic [7:0]        per_eff;
  logic [13:0]       half;
  logic [6:0]        lux_sat;
  logic [26:0]       lux_prod;
  logic [7:0]        steady_bright;
  logic [14:0]       cnt_inc;
  logic [DIV_W:0]    rem_shift;
  logic              ge;

  assign per_eff   = (cfg.breathe_period == 8'd0) ? 8'd1 : cfg.breathe_period;
  assign half      = 14'({6'd0, per_eff} * RAMP_STEP);
  assign lux_sat   = (cfg.lux_percent > LUX_MAX) ? LUX_MAX : cfg.lux_percent;
  assign lux_prod  = {20'd0, lux_sat} * {6'd0, LUX_RECIP};
  assign steady_bright = lux_prod[LUX_SHIFT +: 8];
  assign cnt_inc   = {1'b0, ramp_count} + 15'd1;
  assign rem_shift = {rem, dvd[DVD_W-1]};
  assign ge        = rem_shift >= {1'b0, divisor};

  assign tick_ready       = (state == ST_IDLE);
  assign push             = (state == ST_PUSH) && !q_full;
  assign push_data.bright = (|quot[DVD_W-1:8]) ? 8'hFF : quot[7:0];
  assign push_data.color  = color;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ramp_count   <= '0;
      ramp_falling <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (tick_valid && tick) begin
            color <= cfg.color;
            rem   <= '0;
            step  <= '0;
            if (cfg.mode == MODE_STEADY) begin
              quot  <= DVD_W'(steady_bright);
              state <= ST_PUSH;
            end else if (cfg.mode == MODE_BREATHE) begin
              quot    <= '0;
              dvd     <= DVD_W'({8'd0, ramp_count} * FULL_SCALE);
              divisor <= half;
              state   <= ST_DIV;
              if (!ramp_falling) begin
                if (cnt_inc > {1'b0, half}) begin
                  ramp_count   <= half;
                  ramp_falling <= 1'b1;
                end else begin
                  ramp_count <= cnt_inc[13:0];
                end
              end else if (ramp_count <= 14'd2) begin
                ramp_count   <= 14'd1;
                ramp_falling <= 1'b0;
              end else begin
                ramp_count <= ramp_count - 14'd1;
              end
            end else begin
              quot  <= '0;
              state <= ST_PUSH;
            end
          end
        end
        ST_DIV: begin
          rem  <= ge ? DIV_W'(rem_shift - {1'b0, divisor}) : rem_shift[DIV_W-1:0];
          dvd  <= {dvd[DVD_W-2:0], 1'b0};
          quot <= {quot[DVD_W-2:0], ge};
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/rlbwe_queue.sv
// short queue of frame descriptors between the front and back parts
// uses rlbwe_pkg

module rlbwe_queue #(
  parameter int DEPTH = rlbwe_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  rlbwe_pkg::q_req_t  req,
  input  rlbwe_pkg::frame_t  wr_data,
  output rlbwe_pkg::frame_t  rd_data,
  output rlbwe_pkg::q_stat_t stat
);
  import rlbwe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = slots[rptr];
  assign do_push    = req.push && !stat.full;
  assign do_pop     = req.pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !req.push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> !req.pop) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: design/rlbwe_back.sv
// back part: turns one frame descriptor into a run of pwm compare beats
// uses rlbwe_pkg; one beat per cycle while the result side is ready, through an output register

module rlbwe_back #(
  parameter int PIXELS      = rlbwe_pkg::DEF_PIXELS,
  parameter int RESET_SLOTS = rlbwe_pkg::DEF_RESET_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  rlbwe_pkg::cfg_t    cfg,
  input  rlbwe_pkg::frame_t  rd_data,
  input  logic               q_empty,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [5:0]         duty,
  output logic [5:0]         slot_index,
  output logic               last
);
  import rlbwe_pkg::*;

  localparam int DATA_SLOTS  = PIXELS * BITS_PER_PIXEL;
  localparam int FRAME_SLOTS = DATA_SLOTS + RESET_SLOTS;
  localparam int SLOT_W      = $clog2(FRAME_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(FRAME_SLOTS - 1);
  localparam logic [SLOT_W-1:0] DATA_FIRST = SLOT_W'(LEAD_SLOTS);
  localparam logic [SLOT_W-1:0] DATA_END   = SLOT_W'(LEAD_SLOTS + DATA_SLOTS);

  logic              active;
  logic [SLOT_W-1:0] slot;
  frame_t            cur;

  logic              load;
  logic              in_data;
  logic [SLOT_W-1:0] d;
  logic [1:0]        ch;
  logic              ch_en;
  logic [7:0]        lvl;
  logic              bit_val;
  logic [5:0]        duty_next;

  assign pop     = !active && !q_empty;
  assign load    = active && (!res_valid || res_ready);
  assign in_data = (slot >= DATA_FIRST) && (slot < DATA_END);
  assign d       = slot - DATA_FIRST;
  assign ch      = d[4:3];

  always_comb begin
    case (ch)
      2'd0:    ch_en = cur.color[0];
      2'd1:    ch_en = cur.color[1];
      default: ch_en = cur.color[2];
    endcase
    lvl       = ch_en ? cur.bright : 8'd0;
    bit_val   = (d < SLOT_W'(BITS_PER_PIXEL)) && lvl[3'd7 - d[2:0]];
    duty_next = !in_data ? 6'd0 : (bit_val ? cfg.duty_one : cfg.duty_zero);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_data;
    end
    if (load) begin
      duty       <= duty_next;
      slot_index <= 6'(slot);
      last       <= (slot == SLOT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      slot      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
        slot   <= '0;
      end
      if (load) begin
        res_valid <= 1'b1;
        slot      <= slot + 1'b1;
        if (slot == SLOT_LAST) begin
          active <= 1'b0;
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (res_valid && last) |-> (slot_index == 6'(FRAME_SLOTS - 1)))
    else $error("last beat at wrong slot");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (slot <= SLOT_LAST)) else $error("slot counter past frame end");
`endif

endmodule

FILE: design/rgb_led_breathing_waveform_encoder.sv
// top level of the rgb led breathing waveform encoder
// uses rlbwe_pkg, rlbwe_front, rlbwe_queue, rlbwe_back
//
//  channel   handshake               payload
//  tick      tick_valid/tick_ready   tick
//  result    res_valid/res_ready     duty, slot_index, last
//  config    cfg_valid/cfg_ready     cfg_index, cfg_data
//
// in the front a tick with mode off or steady goes straight to the push state,
// breathe first runs the one bit per cycle divider; a tick of zero pushes
// nothing; the back pops each frame from the two entry queue, then sends
// its PIXELS*24+RESET_SLOTS beats, one per cycle while res_ready is high
// synchronous reset; no clearing pass, the block takes ticks right after reset
// a stalled result side fills the queue and then holds tick_ready low

module rgb_led_breathing_waveform_encoder #(
  parameter int PIXELS      = rlbwe_pkg::DEF_PIXELS,
  parameter int RESET_SLOTS = rlbwe_pkg::DEF_RESET_SLOTS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick_valid,
  output logic       tick_ready,
  input  logic       tick,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [5:0] duty,
  output logic [5:0] slot_index,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import rlbwe_pkg::*;

  cfg_t    cfg;
  frame_t  push_data;
  frame_t  rd_data;
  q_req_t  q_req;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_OFF;
      cfg.color          <= '0;
      cfg.lux_percent    <= '0;
      cfg.breathe_period <= RST_PERIOD;
      cfg.duty_one       <= RST_DUTY_ONE;
      cfg.duty_zero      <= RST_DUTY_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:      cfg.mode           <= cfg_data[1:0];
        REG_COLOR:     cfg.color          <= cfg_data[2:0];
        REG_LUX:       cfg.lux_percent    <= cfg_data[6:0];
        REG_PERIOD:    cfg.breathe_period <= cfg_data;
        REG_DUTY_ONE:  cfg.duty_one       <= cfg_data[5:0];
        REG_DUTY_ZERO: cfg.duty_zero      <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  assign q_req.push = push;
  assign q_req.pop  = pop;

  rlbwe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_ready (tick_ready),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_stat.full)
  );

  rlbwe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .req     (q_req),
    .wr_data (push_data),
    .rd_data (rd_data),
    .stat    (q_stat)
  );

  rlbwe_back #(
    .PIXELS      (PIXELS),
    .RESET_SLOTS (RESET_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rd_data    (rd_data),
    .q_empty    (q_stat.empty),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .duty       (duty),
    .slot_index (slot_index),
    .last       (last)
  );

endmodule

FILE: tb/rgb_led_breathing_waveform_encoder_tb.sv
`timescale 1ns / 100ps

// self-checking testbench for rgb_led_breathing_waveform_encoder: predicts each frame of pwm slots
// from the register settings and ramp state, and checks every result beat in order
// depends on rlbwe_pkg and the encoder design sources

module rgb_led_breathing_waveform_encoder_tb;
  import rlbwe_pkg::*;

  localparam int PIXELS        = DEF_PIXELS;
  localparam int RESET_SLOTS   = DEF_RESET_SLOTS;
  localparam int DATA_SLOTS    = PIXELS * BITS_PER_PIXEL;
  localparam int FRAME_SLOTS   = DATA_SLOTS + RESET_SLOTS;
  localparam int TICKS_WANTED  = 410;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [5:0] duty;
    logic [5:0] slot_index;
    logic       last;
  } slot_t;

  class led_frame_scoreboard;
    logic [1:0]  mode;
    logic [2:0]  color;
    logic [6:0]  lux;
    logic [7:0]  period;
    logic [5:0]  duty_one;
    logic [5:0]  duty_zero;
    logic [13:0] ramp_count;
    logic        ramp_falling;
    slot_t       pending_slots[$];
    int          errors;

    function new();
      mode         = MODE_OFF;
      color        = '0;
      lux          = '0;
      period       = RST_PERIOD;
      duty_one     = RST_DUTY_ONE;
      duty_zero    = RST_DUTY_ZERO;
      ramp_count   = '0;
      ramp_falling = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        REG_MODE:      mode      = data[1:0];
        REG_COLOR:     color     = data[2:0];
        REG_LUX:       lux       = data[6:0];
        REG_PERIOD:    period    = data[7:0];
        REG_DUTY_ONE:  duty_one  = data[5:0];
        REG_DUTY_ZERO: duty_zero = data[5:0];
        default: ;
      endcase
    endfunction

    // level from the ramp, then one step of the triangle
    function logic [7:0] breathe_level();
      int unsigned half;
      int unsigned lvl;
      half = ((period == 8'd0) ? 32'd1 : 32'(period)) * 32'(RAMP_STEP);
      lvl  = 32'(ramp_count) * 32'(FULL_SCALE) / half;
      if (lvl > 32'(FULL_SCALE)) lvl = 32'(FULL_SCALE);
      if (!ramp_falling) begin
        if (32'(ramp_count) + 32'd1 > half) begin
          ramp_count   = 14'(half);
          ramp_falling = 1'b1;
        end else begin
          ramp_count = ramp_count + 14'd1;
        end
      end else if (ramp_count <= 14'd2) begin
        ramp_count   = 14'd1;
        ramp_falling = 1'b0;
      end else begin
        ramp_count = ramp_count - 14'd1;
      end
      return lvl[7:0];
    endfunction

    function void note_tick(logic t);
      logic [7:0] bright;
      logic [7:0] lvl;
      logic [6:0] lux_sat;
      logic       bitv;
      int         d;
      slot_t      s;
      if (!t) return;
      bright = '0;
      if (mode == MODE_STEADY) begin
        lux_sat = (lux > LUX_MAX) ? LUX_MAX : lux;
        bright  = 8'(32'(lux_sat) * 32'(FULL_SCALE) / 32'(LUX_DIVISOR));
      end else if (mode == MODE_BREATHE) begin
        bright = breathe_level();
      end
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        s.duty       = '0;
        s.slot_index = 6'(i);
        s.last       = (i == FRAME_SLOTS - 1);
        if (i >= LEAD_SLOTS && i < LEAD_SLOTS + DATA_SLOTS) begin
          d    = i - LEAD_SLOTS;
          bitv = 1'b0;
          if (d < BITS_PER_PIXEL) begin
            lvl  = color[d / 8] ? bright : 8'd0;
            bitv = lvl[7 - d % 8];
          end
          s.duty = bitv ? duty_one : duty_zero;
        end
        pending_slots.push_back(s);
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_slot(logic [5:0] duty, logic [5:0] slot_index, logic last);
      slot_t want;
      if (pending_slots.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected: slot %0d duty %0d last %0b",
                                  slot_index, duty, last));
        return;
      end
      want = pending_slots.pop_front();
      if (duty !== want.duty)
        report_mismatch($sformatf("slot %0d duty %0d, expected %0d",
                                  want.slot_index, duty, want.duty));
      if (slot_index !== want.slot_index)
        report_mismatch($sformatf("slot_index %0d, expected %0d", slot_index, want.slot_index));
      if (last !== want.last)
        report_mismatch($sformatf("slot %0d last %0b, expected %0b",
                                  want.slot_index, last, want.last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       tick_valid;
  logic       tick_ready;
  logic       tick;
  logic       res_valid;
  logic       res_ready;
  logic [5:0] duty;
  logic [5:0] slot_index;
  logic       last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  led_frame_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int cycles;

  rgb_led_breathing_waveform_encoder #(
    .PIXELS(PIXELS),
    .RESET_SLOTS(RESET_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_ready(tick_ready),
    .tick(tick),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .duty(duty),
    .slot_index(slot_index),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (tick_valid && tick_ready) sb.note_tick(tick);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (res_valid && res_ready) sb.check_slot(duty, slot_index, last);
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_tick(input logic t);
    if ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    tick_valid <= 1'b1;
    tick       <= t;
    do @(posedge clk); while (!tick_ready);
  endtask

  task automatic drain();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] with_junk(logic [7:0] v, logic [7:0] keep);
    return ($urandom_range(3) == 0) ? (v | (8'($urandom_range(255)) & ~keep)) : v;
  endfunction

  task automatic set_config(input logic [1:0] m, input logic [2:0] c, input logic [6:0] l,
                            input logic [7:0] p, input logic [5:0] d1, input logic [5:0] d0,
                            input bit spare);
    logic [2:0] idx[$];
    logic [7:0] val[$];
    drain();
    if (spare) begin
      idx.push_back($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO);
      val.push_back(8'($urandom_range(255)));
    end
    idx.push_back(REG_MODE);      val.push_back(with_junk({6'd0, m}, 8'h03));
    idx.push_back(REG_COLOR);     val.push_back(with_junk({5'd0, c}, 8'h07));
    idx.push_back(REG_LUX);       val.push_back(with_junk({1'b0, l}, 8'h7f));
    idx.push_back(REG_PERIOD);    val.push_back(p);
    idx.push_back(REG_DUTY_ONE);  val.push_back(with_junk({2'd0, d1}, 8'h3f));
    idx.push_back(REG_DUTY_ZERO); val.push_back(with_junk({2'd0, d0}, 8'h3f));
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [1:0] m;
    logic [2:0] c;
    logic [6:0] l;
    logic [7:0] p;
    logic [5:0] d1;
    logic [5:0] d0;
    logic       t;
    int         r;
    int         n;
    int         phase;
    int         ticks_sent;

    sb            = new();
    rst           = 1'b1;
    tick_valid    = 1'b0;
    tick          = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    cycles        = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, steady extremes, unused mode, breathe with zero and max period
    send_tick(1'b1);
    send_tick(1'b0);
    set_config(MODE_STEADY, 3'd7, LUX_MAX, 8'd1, 6'd59, 6'd0, 1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    set_config(MODE_STEADY, 3'd5, 7'd127, 8'd1, 6'd63, 6'd63, 1'b1);
    send_tick(1'b1);
    set_config(MODE_STEADY, 3'd2, 7'd0, 8'd1, RST_DUTY_ONE, RST_DUTY_ZERO, 1'b0);
    send_tick(1'b1);
    set_config(MODE_STEADY, 3'd3, 7'd37, 8'd1, 6'd0, 6'd59, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    set_config(MODE_UNUSED, 3'd7, LUX_MAX, 8'd1, 6'd59, 6'd0, 1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    set_config(MODE_BREATHE, 3'd7, 7'd0, 8'd0, RST_DUTY_ONE, RST_DUTY_ZERO, 1'b0);
    repeat (4) send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    set_config(MODE_BREATHE, 3'd1, 7'd0, 8'd255, 6'd1, 6'd58, 1'b1);
    repeat (2) send_tick(1'b1);
    set_config(MODE_OFF, 3'd7, LUX_MAX, 8'd2, 6'd59, 6'd0, 1'b0);
    send_tick(1'b1);

    phase      = 0;
    ticks_sent = 0;
    while (ticks_sent < TICKS_WANTED) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase

      r = $urandom_range(9);
      m = (r == 0) ? MODE_OFF : (r < 3) ? MODE_STEADY : (r < 9) ? MODE_BREATHE : MODE_UNUSED;
      c = 3'($urandom_range(7));
      r = $urandom_range(3);
      l = (r == 0) ? LUX_MAX : (r == 1) ? 7'($urandom_range(101, 127)) : 7'($urandom_range(100));
      r = $urandom_range(9);
      p = (r < 6) ? 8'($urandom_range(1, 3)) : (r == 6) ? 8'd0 :
          (r == 7) ? 8'd255 : 8'($urandom_range(255));
      d1 = ($urandom_range(7) == 0) ? 6'd63 : 6'($urandom_range(59));
      d0 = ($urandom_range(7) == 0) ? 6'd63 : 6'($urandom_range(59));
      set_config(m, c, l, p, d1, d0, $urandom_range(7) == 0);

      n = $urandom_range(12, 36);
      // long receiver hold-off while ticks keep coming, so the input side backs up
      if (phase == 2) hold_left = 400;
      for (int k = 0; k < n; k++) begin
        if (phase == 5 && k == n / 2) drain();
        t = ($urandom_range(9) != 0);
        send_tick(t);
        ticks_sent++;
      end
      phase++;
    end

    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
